@@ src/smx_pkg.sv @@
// Shared types and constants for the seeded mask expander.
`timescale 1ns / 1ps
`default_nettype none

package smx_pkg;

   localparam int WORD_W = 64;
   localparam int WORDS  = 4;
   localparam int CMD_W  = 2;

   localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SUB  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_GEN  = 2'd2;

   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic [1:0] {
      SMX_IDLE,
      SMX_SEED,
      SMX_MASK,
      SMX_DONE
   } state_type;

endpackage

`default_nettype wire

@@ src/smx_xoro_unit.sv @@
// Shared xoroshiro128++ step: output word and advanced state for one generator.
`timescale 1ns / 1ps
`default_nettype none

module smx_xoro_unit (
   input  smx_pkg::word_type a,
   input  smx_pkg::word_type b,
   output smx_pkg::word_type out_word,
   output smx_pkg::word_type next_a,
   output smx_pkg::word_type next_b
);

   smx_pkg::word_type sum;
   smx_pkg::word_type mix;

   always_comb begin
      sum      = a + b;
      out_word = {sum[46:0], sum[63:47]} + a;           // rotl 17
      mix      = a ^ b;
      next_a   = {a[14:0], a[63:15]} ^ mix ^ {mix[42:0], 21'd0};  // rotl 49
      next_b   = {mix[35:0], mix[63:36]};               // rotl 28
   end

endmodule

`default_nettype wire

@@ src/seeded_mask_expander_four_lane.sv @@
// Top level: four-lane seeded mask expander around one shared xoroshiro128++ unit.
// Seed beat: base steps, one base step per cycle, draw two words for each lane state;
//   mask beat: one lane per cycle, the subtract one stage behind; unused command goes
//   straight to done. Each result then passes through the output register.
// Flow: one beat at a time, req_stall high until the result moves to the output
//   register, so a new beat is not taken before the last one is through.
// Reset: synchronous, active high; clears base and lane states, seeded flag and control.
`timescale 1ns / 1ps
`default_nettype none

module seeded_mask_expander_four_lane #(
   parameter int LANES = 4
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [smx_pkg::CMD_W-1:0]   req_command,
   input  wire smx_pkg::word_type           req_word_0,
   input  wire smx_pkg::word_type           req_word_1,
   input  wire smx_pkg::word_type           req_word_2,
   input  wire smx_pkg::word_type           req_word_3,
   // response channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output smx_pkg::word_type                rsp_result_0,
   output smx_pkg::word_type                rsp_result_1,
   output smx_pkg::word_type                rsp_result_2,
   output smx_pkg::word_type                rsp_result_3,
   output logic                             rsp_seeded
);

   localparam int LIDX_W = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int CNT_W  = $clog2(2 * LANES + 1);
   localparam logic [CNT_W-1:0] SEED_LAST = CNT_W'(2 * LANES - 1);
   localparam logic [CNT_W-1:0] MASK_LAST = CNT_W'(LANES);

   // ---------------------------------------------------------------- state
   smx_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [smx_pkg::CMD_W-1:0] cmd_ff;

   smx_pkg::word_type  base_a_ff, base_b_ff;
   smx_pkg::word_type  lane_a_ff [LANES];
   smx_pkg::word_type  lane_b_ff [LANES];
   smx_pkg::word_type  coef_ff   [smx_pkg::WORDS];
   smx_pkg::word_type  res_ff    [smx_pkg::WORDS];
   logic               seed_done_ff;

   // mask pipeline stage: raw mask word waiting for the subtract
   smx_pkg::word_type  mask_ff;
   logic [LIDX_W-1:0]  idx_ff;
   logic               mask_vld_ff;

   // output register
   logic               rsp_valid_ff;
   smx_pkg::word_type  rsp_res_ff [smx_pkg::WORDS];
   logic               rsp_seeded_ff;

   // ---------------------------------------------------------------- control
   logic accept;
   logic seed_step;
   logic mask_step;
   logic out_load;

   logic [LIDX_W-1:0] seed_lane;
   logic [LIDX_W-1:0] mask_lane;

   assign accept    = req_valid && !req_stall;
   assign seed_lane = cnt_ff[LIDX_W:1];
   assign mask_lane = cnt_ff[LIDX_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         smx_pkg::SMX_IDLE: begin
            if (accept) begin
               if (req_command == smx_pkg::CMD_LOAD) begin
                  state_in = smx_pkg::SMX_SEED;
               end else if (req_command == smx_pkg::CMD_SUB ||
                            req_command == smx_pkg::CMD_GEN) begin
                  state_in = smx_pkg::SMX_MASK;
               end else begin
                  state_in = smx_pkg::SMX_DONE;
               end
            end
         end
         smx_pkg::SMX_SEED: begin
            if (cnt_ff == SEED_LAST) state_in = smx_pkg::SMX_DONE;
         end
         smx_pkg::SMX_MASK: begin
            if (cnt_ff == MASK_LAST) state_in = smx_pkg::SMX_DONE;
         end
         smx_pkg::SMX_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = smx_pkg::SMX_IDLE;
         end
         default: state_in = smx_pkg::SMX_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall = 1'b1;
      seed_step = 1'b0;
      mask_step = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         smx_pkg::SMX_IDLE: req_stall = 1'b0;
         smx_pkg::SMX_SEED: seed_step = 1'b1;
         smx_pkg::SMX_MASK: mask_step = (cnt_ff != MASK_LAST);
         smx_pkg::SMX_DONE: out_load  = !rsp_valid_ff || !rsp_stall;
         default: req_stall = 1'b1;
      endcase
   end

   assign cnt_in = accept ? '0 : (seed_step || mask_step) ? cnt_ff + CNT_W'(1) : cnt_ff;

   // ---------------------------------------------------------------- shared unit
   smx_pkg::word_type unit_a, unit_b, unit_out, unit_next_a, unit_next_b;

   always_comb begin
      if (state_ff == smx_pkg::SMX_SEED) begin
         unit_a = base_a_ff;
         unit_b = base_b_ff;
      end else begin
         unit_a = lane_a_ff[mask_lane];
         unit_b = lane_b_ff[mask_lane];
      end
   end

   smx_xoro_unit u_xoro (
      .a        (unit_a),
      .b        (unit_b),
      .out_word (unit_out),
      .next_a   (unit_next_a),
      .next_b   (unit_next_b)
   );

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= smx_pkg::SMX_IDLE;
         cnt_ff        <= '0;
         seed_done_ff  <= 1'b0;
         mask_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         mask_vld_ff <= mask_step;
         if (accept && req_command == smx_pkg::CMD_LOAD) seed_done_ff <= 1'b1;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // generator state; reset clears it since unseeded masks run from zero
   always_ff @(posedge clock) begin
      if (reset) begin
         base_a_ff <= '0;
         base_b_ff <= '0;
         for (int i = 0; i < LANES; i++) begin
            lane_a_ff[i] <= '0;
            lane_b_ff[i] <= '0;
         end
      end else begin
         if (accept && req_command == smx_pkg::CMD_LOAD) begin
            base_a_ff <= req_word_0;
            base_b_ff <= req_word_1;
         end else if (seed_step) begin
            base_a_ff <= unit_next_a;
            base_b_ff <= unit_next_b;
            // even steps fill the first word, odd steps the second
            if (cnt_ff[0]) begin
               lane_b_ff[seed_lane] <= unit_out;
            end else begin
               lane_a_ff[seed_lane] <= unit_out;
            end
         end
         if (mask_step) begin
            lane_a_ff[mask_lane] <= unit_next_a;
            lane_b_ff[mask_lane] <= unit_next_b;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= req_command;
         coef_ff[0] <= req_word_0;
         coef_ff[1] <= req_word_1;
         coef_ff[2] <= req_word_2;
         coef_ff[3] <= req_word_3;
         for (int w = 0; w < smx_pkg::WORDS; w++) res_ff[w] <= '0;
      end else if (mask_vld_ff) begin
         for (int w = 0; w < smx_pkg::WORDS; w++) begin
            if (4'(idx_ff) == 4'(w)) begin
               res_ff[w] <= (cmd_ff == smx_pkg::CMD_SUB) ? coef_ff[w] - mask_ff : mask_ff;
            end
         end
      end
      if (mask_step) begin
         mask_ff <= unit_out;
         idx_ff  <= mask_lane;
      end
      if (out_load) begin
         for (int w = 0; w < smx_pkg::WORDS; w++) rsp_res_ff[w] <= res_ff[w];
         rsp_seeded_ff <= seed_done_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_result_0 = rsp_res_ff[0];
   assign rsp_result_1 = rsp_res_ff[1];
   assign rsp_result_2 = rsp_res_ff[2];
   assign rsp_result_3 = rsp_res_ff[3];
   assign rsp_seeded   = rsp_seeded_ff;

   // ---------------------------------------------------------------- assertions
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == smx_pkg::SMX_DONE))
      else $error("response raised outside the done state");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == smx_pkg::SMX_DONE && rsp_valid_ff && rsp_stall)
      |=> state_ff == smx_pkg::SMX_DONE)
      else $error("result left done while output register was full");

   a_seed_cnt: assert property (@(posedge clock) disable iff (reset)
      seed_step |-> cnt_ff <= SEED_LAST)
      else $error("seed counter overran");

   a_mask_after_step: assert property (@(posedge clock) disable iff (reset)
      mask_vld_ff |-> $past(state_ff == smx_pkg::SMX_MASK) && 32'(idx_ff) < LANES)
      else $error("mask stage valid without a lane step");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the four-lane seeded mask expander.
`timescale 1ns / 1ps

module tb_top;

   localparam int LANES = 4;
   // Command code with no operation behind it; the block must leave state alone.
   localparam logic [smx_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int RANDOM_BEATS = 1600;
   localparam int IDLE_PCT     = 17;
   // Cycle window in which neither side idles or stalls.
   localparam int CALM_START   = 6000;
   localparam int CALM_END     = 12000;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic [smx_pkg::CMD_W-1:0] command;
      smx_pkg::word_type         word [smx_pkg::WORDS];
   } req_beat_type;

   typedef struct {
      smx_pkg::word_type result [smx_pkg::WORDS];
      logic              seeded;
   } rsp_beat_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;

   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   logic [smx_pkg::CMD_W-1:0] req_command = smx_pkg::CMD_GEN;
   smx_pkg::word_type         req_word_0  = '0;
   smx_pkg::word_type         req_word_1  = '0;
   smx_pkg::word_type         req_word_2  = '0;
   smx_pkg::word_type         req_word_3  = '0;

   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   smx_pkg::word_type rsp_result_0;
   smx_pkg::word_type rsp_result_1;
   smx_pkg::word_type rsp_result_2;
   smx_pkg::word_type rsp_result_3;
   logic              rsp_seeded;

   seeded_mask_expander_four_lane #(
      .LANES(LANES)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_word_0  (req_word_0),
      .req_word_1  (req_word_1),
      .req_word_2  (req_word_2),
      .req_word_3  (req_word_3),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_result_0(rsp_result_0),
      .rsp_result_1(rsp_result_1),
      .rsp_result_2(rsp_result_2),
      .rsp_result_3(rsp_result_3),
      .rsp_seeded  (rsp_seeded)
   );

   // ---------------------------------------------------------------------
   // Predictor state: base generator, lane bank, seeded flag.
   // Everything starts at zero, matching the block after reset.
   // ---------------------------------------------------------------------
   smx_pkg::word_type base_lo = '0;
   smx_pkg::word_type base_hi = '0;
   smx_pkg::word_type lane_a [LANES] = '{default: '0};
   smx_pkg::word_type lane_b [LANES] = '{default: '0};
   logic              seed_loaded = 1'b0;

   req_beat_type beats_to_send [$];
   rsp_beat_type mask_results_due [$];
   req_beat_type beat_on_bus;

   int  cycle_count = 0;
   int  error_count = 0;
   logic calm;

   assign calm = (cycle_count >= CALM_START) && (cycle_count < CALM_END);

   function automatic smx_pkg::word_type rotl(smx_pkg::word_type v, int unsigned n);
      return (v << n) | (v >> (smx_pkg::WORD_W - n));
   endfunction

   // xoroshiro128++ output word for state (a, b)
   function automatic smx_pkg::word_type xo_output(smx_pkg::word_type a,
                                                   smx_pkg::word_type b);
      return rotl(a + b, 17) + a;
   endfunction

   function automatic void xo_advance(inout smx_pkg::word_type a,
                                      inout smx_pkg::word_type b);
      smx_pkg::word_type mix;
      mix = a ^ b;
      a   = rotl(a, 49) ^ mix ^ (mix << 21);
      b   = rotl(mix, 28);
   endfunction

   function automatic smx_pkg::word_type base_draw();
      smx_pkg::word_type o;
      o = xo_output(base_lo, base_hi);
      xo_advance(base_lo, base_hi);
      return o;
   endfunction

   // Apply one request beat to the predictor state and return the result beat.
   function automatic rsp_beat_type mask_lane_step(req_beat_type b);
      rsp_beat_type      r;
      smx_pkg::word_type mask;
      r.result = '{default: '0};
      case (b.command)
         smx_pkg::CMD_LOAD: begin
            // seed word 0 is the low half, word 1 the high half
            base_lo = b.word[0];
            base_hi = b.word[1];
            for (int i = 0; i < LANES; i++) begin
               lane_a[i] = base_draw();
               lane_b[i] = base_draw();
            end
            seed_loaded = 1'b1;
         end
         smx_pkg::CMD_SUB, smx_pkg::CMD_GEN: begin
            for (int i = 0; i < LANES; i++) begin
               mask = xo_output(lane_a[i], lane_b[i]);
               if (i < smx_pkg::WORDS)
                  r.result[i] = (b.command == smx_pkg::CMD_SUB) ? b.word[i] - mask : mask;
               xo_advance(lane_a[i], lane_b[i]);
            end
         end
         default: ;  // unused command: no state change, zero words
      endcase
      r.seeded = seed_loaded;
      return r;
   endfunction

   function automatic void queue_beat(logic [smx_pkg::CMD_W-1:0] cmd,
                                      smx_pkg::word_type w0, smx_pkg::word_type w1,
                                      smx_pkg::word_type w2, smx_pkg::word_type w3);
      req_beat_type b;
      b.command = cmd;
      b.word    = '{w0, w1, w2, w3};
      beats_to_send.push_back(b);
   endfunction

   // Mostly full-width random words, with zero, all ones and one-hot mixed in.
   function automatic smx_pkg::word_type rand_word();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         2:       return smx_pkg::word_type'(1) << $urandom_range(0, smx_pkg::WORD_W - 1);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------
   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // ---------------------------------------------------------------------
   // Request driver: holds a beat while stalled, otherwise presents the
   // next pending beat unless it decides to idle this cycle.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            mask_results_due.push_back(mask_lane_step(beat_on_bus));
         if (!req_valid || !req_stall) begin
            if (beats_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               beat_on_bus = beats_to_send.pop_front();
               req_command <= beat_on_bus.command;
               req_word_0  <= beat_on_bus.word[0];
               req_word_1  <= beat_on_bus.word[1];
               req_word_2  <= beat_on_bus.word[2];
               req_word_3  <= beat_on_bus.word[3];
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: checks each accepted beat against the oldest
   // prediction, then picks the stall for the next cycle.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_beat_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (mask_results_due.size() == 0) begin
               if (error_count < 10)
                  $display("[%0d] result beat with no prediction: %h %h %h %h seeded=%b",
                           cycle_count, rsp_result_0, rsp_result_1, rsp_result_2,
                           rsp_result_3, rsp_seeded);
               error_count++;
            end else begin
               want = mask_results_due.pop_front();
               if (rsp_result_0 !== want.result[0] || rsp_result_1 !== want.result[1] ||
                   rsp_result_2 !== want.result[2] || rsp_result_3 !== want.result[3] ||
                   rsp_seeded !== want.seeded) begin
                  if (error_count < 10) begin
                     $display("[%0d] mismatch exp: %h %h %h %h seeded=%b", cycle_count,
                              want.result[0], want.result[1], want.result[2],
                              want.result[3], want.seeded);
                     $display("[%0d] mismatch got: %h %h %h %h seeded=%b", cycle_count,
                              rsp_result_0, rsp_result_1, rsp_result_2, rsp_result_3,
                              rsp_seeded);
                  end
                  error_count++;
               end
            end
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ---------------------------------------------------------------------
   initial begin
      int  queued;
      int  run_len;
      int  pick;
      logic timed_out;

      // Masks before any seed: lanes sit at zero, so every mask is zero.
      queue_beat(smx_pkg::CMD_GEN, '0, '0, '0, '0);
      queue_beat(smx_pkg::CMD_SUB, '1, '1, '1, '1);
      queue_beat(CMD_UNUSED, rand_word(), rand_word(), rand_word(), rand_word());
      // All-zero seed keeps the generator stuck at zero.
      queue_beat(smx_pkg::CMD_LOAD, '0, '0, '1, '1);
      queue_beat(smx_pkg::CMD_GEN, '1, '1, '1, '1);
      // All-ones seed, then subtract against the word extremes.
      queue_beat(smx_pkg::CMD_LOAD, '1, '1, '1, '1);
      queue_beat(smx_pkg::CMD_GEN, '0, '0, '0, '0);
      queue_beat(smx_pkg::CMD_SUB, '0, '0, '0, '0);
      queue_beat(smx_pkg::CMD_SUB, '1, '1, '1, '1);
      queue_beat(smx_pkg::CMD_SUB, {1'b1, 63'd0}, {1'b1, 63'd0}, 64'd1, 64'd1);
      // Unused command between masks must not advance the lanes.
      queue_beat(CMD_UNUSED, '1, '1, '1, '1);
      queue_beat(smx_pkg::CMD_GEN, '0, '0, '0, '0);
      // Reload with the same seed twice: the stream restarts.
      queue_beat(smx_pkg::CMD_LOAD, 64'd1, '0, '0, '0);
      queue_beat(smx_pkg::CMD_GEN, '0, '0, '0, '0);
      queue_beat(smx_pkg::CMD_GEN, '0, '0, '0, '0);
      queue_beat(smx_pkg::CMD_LOAD, 64'd1, '0, rand_word(), rand_word());
      queue_beat(smx_pkg::CMD_GEN, '0, '0, '0, '0);
      queue_beat(smx_pkg::CMD_LOAD, '0, {1'b1, 63'd0}, '0, '0);
      queue_beat(smx_pkg::CMD_SUB, rand_word(), rand_word(), rand_word(), rand_word());
      queue_beat(smx_pkg::CMD_GEN, rand_word(), rand_word(), rand_word(), rand_word());

      // Random part: seed followed by a run of mask beats; now and then the
      // reload is skipped so a stream runs on, and a few unused commands sneak in.
      queued = 0;
      while (queued < RANDOM_BEATS) begin
         if ($urandom_range(0, 7) != 0) begin
            queue_beat(smx_pkg::CMD_LOAD, rand_word(), rand_word(), rand_word(),
                       rand_word());
            queued++;
         end
         run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 30);
         for (int k = 0; k < run_len; k++) begin
            pick = $urandom_range(0, 99);
            queue_beat((pick < 3) ? CMD_UNUSED :
                       (pick < 50) ? smx_pkg::CMD_SUB : smx_pkg::CMD_GEN,
                       rand_word(), rand_word(), rand_word(), rand_word());
            queued++;
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Sample on the falling edge so queue and valid state are settled.
      while (!(beats_to_send.size() == 0 && !req_valid && mask_results_due.size() == 0)
             && cycle_count < CYCLE_LIMIT)
         @(negedge clock);
      timed_out = (cycle_count >= CYCLE_LIMIT);
      if (!timed_out)
         repeat (DRAIN_CYCLES) @(negedge clock);

      if (mask_results_due.size() != 0)
         $display("%0d predicted result beats never arrived", mask_results_due.size());
      if (timed_out || error_count != 0 || mask_results_due.size() != 0) begin
         $display("Regression FAIL");
      end else begin
         $display("Regression PASS");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/smx_pkg.sv
src/smx_xoro_unit.sv
src/seeded_mask_expander_four_lane.sv
verif/tb_top.sv
